@@ rtl/core/epmc_pkg.sv @@
package epmc_pkg;

	// Field widths fixed by the interface
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned INDEX_W   = 8;
	localparam int unsigned LEN_CFG_W = 9;
	localparam int unsigned COUNT_W   = 32;

	// Item mode codes
	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_TEXT = 2'd1;
	localparam logic [1:0] MODE_NEW  = 2'd2;

	// Work handed from the input decode to the result stage
	typedef struct packed {
		logic text;
		logic clear;
	} epmc_push_t;

endpackage

@@ rtl/core/epmc_cell.sv @@
module epmc_cell
	import epmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              advance,
	input  logic              clear,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              prev_bit,
	output logic              match_bit
);

	logic [BYTE_W-1:0] pattern_q;
	logic              bit_q;

	// Hold one pattern byte
	always_ff @(posedge clk) begin
		if (load) begin
			pattern_q <= data_byte;
		end
	end

	// Advance the partial match from the neighbor on each text byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (clear) begin
			bit_q <= 1'b0;
		end else if (advance) begin
			bit_q <= prev_bit & (pattern_q == data_byte);
		end
	end

	assign match_bit = bit_q;

endmodule

@@ rtl/core/epmc_tally.sv @@
module epmc_tally
	import epmc_pkg::*;
#(
	parameter int unsigned MAX_PATTERN = 256,
	parameter int unsigned SEL_W       = 8
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  epmc_push_t             push,
	output logic                   ready,
	input  logic [MAX_PATTERN-1:0] cell_bits,
	input  logic [SEL_W-1:0]       last_sel,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   match_here,
	output logic [COUNT_W-1:0]     match_count
);

	logic               s1_valid_s1;
	logic               s1_clear_s1;
	logic               s1_adv;
	logic               hit;
	logic               out_valid_q;
	logic               match_here_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;

	// Advance the select stage when its transaction has somewhere to go
	assign s1_adv = s1_valid_s1 && (s1_clear_s1 || !out_valid_q || out_ready);
	assign ready  = !s1_valid_s1 || s1_adv;

	// Pick the cell at the last pattern position
	assign hit = cell_bits[last_sel];

	// Saturating count
	assign count_next = (hit && (count_q != '1)) ? count_q + COUNT_W'(1) : count_q;

	// Track the select stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			s1_clear_s1 <= 1'b0;
		end else if (ready) begin
			s1_valid_s1 <= push.text | push.clear;
			s1_clear_s1 <= push.clear;
		end
	end

	// Update the count and load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv && s1_clear_s1) begin
				count_q <= '0;
			end else if (s1_adv) begin
				count_q <= count_next;
			end
			if (s1_adv && !s1_clear_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (s1_adv && !s1_clear_s1) begin
			match_here_q <= hit;
			match_count  <= count_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign match_here = match_here_q;

	// A text byte with a hit bumps the count unless saturated
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !s1_clear_s1 && hit && (count_q != '1))
		|=> (count_q == $past(count_q) + COUNT_W'(1)))
		else $error("count did not advance on a hit");

	// A new text drops the count to zero
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && s1_clear_s1) |=> (count_q == '0))
		else $error("count not cleared by new text");

	// A reported match never carries a zero count
	a_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && match_here_q) |-> (match_count != '0))
		else $error("match reported with zero count");

	// Back pressure only comes from a stuck select stage
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!ready |-> (s1_valid_s1 && !s1_clear_s1 && out_valid_q && !out_ready))
		else $error("input stalled without cause");

endmodule

@@ rtl/core/exact_pattern_match_counter.sv @@
// Exact pattern match counter. Load the pattern with mode 0 transactions
// (one byte per index), set pattern_length through the cfg port, start a
// text with a mode 2 transaction, then stream text bytes as mode 1
// transactions. Each text byte returns one result: match_here when a full
// match of the first pattern_length pattern bytes ends at that byte, and
// the saturating match count since the last new text. A row of MAX_PATTERN
// compare cells advances once per text byte, so one transaction is taken
// every cycle unless the result side stalls; a result passes the cell row
// and then the last-position select and count stage, which registers it.
// Mode 0 and mode 2 transactions give no result; mode 3 is ignored. A
// pattern length of 0 acts as 1 and one above MAX_PATTERN acts as
// MAX_PATTERN. Pattern bytes that were never loaded read as unknown.
module exact_pattern_match_counter
	import epmc_pkg::*;
#(
	parameter int unsigned MAX_PATTERN = 256
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [LEN_CFG_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           mode,
	input  logic [INDEX_W-1:0]   pattern_index,
	input  logic [BYTE_W-1:0]    data_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 match_here,
	output logic [COUNT_W-1:0]   match_count
);

	localparam int unsigned SEL_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int unsigned LEN_W   = $clog2(MAX_PATTERN + 1);
	localparam int unsigned CMP_W   = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
	localparam int unsigned LOAD_N  = (MAX_PATTERN < (1 << INDEX_W)) ?
	                                  MAX_PATTERN : (1 << INDEX_W);

	logic                   accept;
	logic                   is_load;
	logic                   is_text;
	logic                   is_new;
	epmc_push_t             push;
	logic [MAX_PATTERN-1:0] cell_bits;
	logic [MAX_PATTERN-1:0] prev_bits;
	logic [SEL_W-1:0]       last_sel_q;
	logic [CMP_W-1:0]       len_ext;
	logic [CMP_W-1:0]       len_use;

	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Decode the mode
	always_comb begin
		is_load = 1'b0;
		is_text = 1'b0;
		is_new  = 1'b0;
		unique case (mode)
			MODE_LOAD: is_load = 1'b1;
			MODE_TEXT: is_text = 1'b1;
			MODE_NEW:  is_new  = 1'b1;
			default:   ;
		endcase
	end

	assign push.text  = accept && is_text;
	assign push.clear = accept && is_new;

	// Clamp the length and keep the last cell position
	assign len_ext = CMP_W'(cfg_data);
	always_comb begin
		if (len_ext == '0) begin
			len_use = CMP_W'(1);
		end else if (len_ext > CMP_W'(MAX_PATTERN)) begin
			len_use = CMP_W'(MAX_PATTERN);
		end else begin
			len_use = len_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sel_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			last_sel_q <= SEL_W'(len_use - CMP_W'(1));
		end
	end

	// Chain the cells
	assign prev_bits = {cell_bits[MAX_PATTERN-1:0] << 1} | MAX_PATTERN'(1);

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic load_i;
		if (i < LOAD_N) begin : g_ld
			assign load_i = accept && is_load && (pattern_index == INDEX_W'(i));
		end else begin : g_nold
			assign load_i = 1'b0;
		end

		epmc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (load_i),
			.advance   (push.text),
			.clear     (push.clear),
			.data_byte (data_byte),
			.prev_bit  (prev_bits[i]),
			.match_bit (cell_bits[i])
		);
	end

	// Select the last position and count
	epmc_tally #(
		.MAX_PATTERN (MAX_PATTERN),
		.SEL_W       (SEL_W)
	) u_tally (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.ready       (in_ready),
		.cell_bits   (cell_bits),
		.last_sel    (last_sel_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.match_here  (match_here),
		.match_count (match_count)
	);

endmodule

@@ verif/tb_exact_pattern_match_counter.sv @@
`timescale 1ns / 100ps
module tb_exact_pattern_match_counter;
	import epmc_pkg::*;

	localparam int unsigned MAX_PATTERN = 256;
	localparam logic [1:0]  MODE_SPARE  = 2'd3;
	localparam int unsigned PHASES      = 9;

	typedef struct packed {
		logic               hit;
		logic [COUNT_W-1:0] count;
	} match_result_t;

	// Track the compare-cell row and the match count, queue one result per text byte
	class match_scoreboard;
		logic [BYTE_W-1:0]    pattern_bytes [MAX_PATTERN];
		logic [MAX_PATTERN-1:0] cell_row;
		logic [COUNT_W-1:0]   found_total;
		logic [LEN_CFG_W-1:0] len_reg;
		match_result_t        due_matches [$];
		int unsigned          errors;
		int unsigned          items_seen;
		int unsigned          results_seen;
		int unsigned          hits_seen;

		function new();
			foreach (pattern_bytes[i]) pattern_bytes[i] = '0;
			cell_row     = '0;
			found_total  = '0;
			len_reg      = LEN_CFG_W'(1);
			errors       = 0;
			items_seen   = 0;
			results_seen = 0;
			hits_seen    = 0;
		endfunction

		function void set_length(logic [LEN_CFG_W-1:0] value);
			len_reg = value;
		endfunction

		function int unsigned pending();
			return due_matches.size();
		endfunction

		// Apply one accepted input transaction
		function void note_item(logic [1:0] m, logic [INDEX_W-1:0] idx, logic [BYTE_W-1:0] b);
			int unsigned   span;
			match_result_t r;
			items_seen++;
			case (m)
				MODE_LOAD: begin
					pattern_bytes[idx] = b;
				end
				MODE_NEW: begin
					cell_row    = '0;
					found_total = '0;
				end
				MODE_TEXT: begin
					// advance every cell at once, top position first
					for (int i = MAX_PATTERN - 1; i > 0; i--)
						cell_row[i] = cell_row[i-1] && (pattern_bytes[i] == b);
					cell_row[0] = (pattern_bytes[0] == b);
					span = 32'(len_reg);
					if (span == 0) span = 1;
					if (span > MAX_PATTERN) span = MAX_PATTERN;
					r.hit = cell_row[span-1];
					if (r.hit && found_total != '1) found_total++;
					r.count = found_total;
					due_matches.push_back(r);
				end
				default: begin
				end
			endcase
		endfunction

		function void note_error(string what, match_result_t want, logic hit,
				logic [COUNT_W-1:0] count);
			errors++;
			if (errors <= 10)
				$display("ERROR %0t: %s: expected match_here=%0b match_count=%0d, got %0b / %0d",
					$time, what, want.hit, want.count, hit, count);
		endfunction

		// Compare one accepted result with the oldest pending one
		function void check_match(logic hit, logic [COUNT_W-1:0] count);
			match_result_t want;
			results_seen++;
			if (hit === 1'b1) hits_seen++;
			if (due_matches.size() == 0) begin
				want = '0;
				note_error("result with nothing pending", want, hit, count);
			end else begin
				want = due_matches.pop_front();
				if (hit !== want.hit)
					note_error("match_here differs", want, hit, count);
				else if (count !== want.count)
					note_error("match_count differs", want, hit, count);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [LEN_CFG_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           mode;
	logic [INDEX_W-1:0]   pattern_index;
	logic [BYTE_W-1:0]    data_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic                 match_here;
	logic [COUNT_W-1:0]   match_count;

	int unsigned       send_idle = 11;
	int unsigned       recv_idle = 46;
	logic [BYTE_W-1:0] sym_a;
	logic [BYTE_W-1:0] sym_b;
	logic [BYTE_W-1:0] pattern_copy [MAX_PATTERN];
	match_scoreboard   sb;

	exact_pattern_match_counter #(
		.MAX_PATTERN(MAX_PATTERN)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.pattern_index(pattern_index),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.match_here   (match_here),
		.match_count  (match_count)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Stall the result side at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Watch every handshake at the rising edge
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cfg_valid && cfg_ready) sb.set_length(cfg_data);
			if (in_valid && in_ready) sb.note_item(mode, pattern_index, data_byte);
			if (out_valid && out_ready) sb.check_match(match_here, match_count);
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [BYTE_W-1:0] pick_byte(int unsigned noise_pct);
		if ($urandom_range(99) < noise_pct) return 8'($urandom_range(255));
		return $urandom_range(1) ? sym_b : sym_a;
	endfunction

	function automatic int unsigned span_of(logic [LEN_CFG_W-1:0] value);
		if (value == 0) return 1;
		if (value > MAX_PATTERN) return MAX_PATTERN;
		return 32'(value);
	endfunction

	function automatic logic [LEN_CFG_W-1:0] phase_length(int unsigned p);
		case (p)
			0: return 9'd2;
			1: return 9'd0;
			2: return 9'd511;
			3: return 9'd5;
			4: return 9'd256;
			5: return 9'd1;
			6: return 9'd300;
			7: return 9'd4;
			default: return 9'd7;
		endcase
	endfunction

	// Send one input transaction; called and returns at a falling edge
	task automatic push_item(input logic [1:0] m, input logic [INDEX_W-1:0] idx,
			input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= m;
		pattern_index <= idx;
		data_byte     <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (m == MODE_LOAD) pattern_copy[idx] = b;
		@(negedge clk);
	endtask

	task automatic write_length(input logic [LEN_CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every pending result, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Random texts: mostly pattern copies and alphabet bytes, some noise
	task automatic run_texts(input int unsigned quota, input int unsigned span);
		int unsigned sent;
		int unsigned pick;
		int unsigned cut;
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				push_item(MODE_NEW, INDEX_W'($urandom_range(255)), 8'($urandom_range(255)));
				sent++;
			end else if (pick < 8) begin
				push_item(MODE_LOAD, INDEX_W'($urandom_range(255)), pick_byte(15));
				sent++;
			end else if (pick < 10) begin
				push_item(MODE_SPARE, INDEX_W'($urandom_range(255)), 8'($urandom_range(255)));
			end else if (pick < 45) begin
				// copy the active pattern, now and then with one byte spoiled
				cut = ($urandom_range(9) == 0) ? $urandom_range(span - 1) : span;
				for (int k = 0; k < span; k++)
					push_item(MODE_TEXT, INDEX_W'($urandom_range(255)),
						(k == cut) ? 8'($urandom_range(255)) : pattern_copy[k]);
				sent += span;
			end else begin
				push_item(MODE_TEXT, INDEX_W'($urandom_range(255)), pick_byte(15));
				sent++;
			end
		end
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		mode          = MODE_LOAD;
		pattern_index = '0;
		data_byte     = '0;
		sym_a         = 8'($urandom_range(255));
		sym_b         = sym_a ^ (8'd1 << $urandom_range(7));
		foreach (pattern_copy[i]) pattern_copy[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill the whole store so no text byte reads an unloaded entry
		for (int i = 0; i < MAX_PATTERN; i++)
			push_item(MODE_LOAD, INDEX_W'(i), pick_byte(5));

		// One-byte pattern at the reset length
		push_item(MODE_NEW, 8'hFF, 8'hFF);
		push_item(MODE_TEXT, 8'h00, pattern_copy[0]);
		push_item(MODE_TEXT, 8'hFF, ~pattern_copy[0]);
		push_item(MODE_TEXT, 8'h00, 8'h00);
		push_item(MODE_TEXT, 8'h00, 8'hFF);
		push_item(MODE_SPARE, 8'hFF, pattern_copy[0]);
		push_item(MODE_LOAD, 8'h00, 8'hFF);
		push_item(MODE_TEXT, 8'h7F, 8'hFF);
		push_item(MODE_LOAD, 8'h00, sym_a);
		push_item(MODE_NEW, 8'h00, 8'h00);
		push_item(MODE_TEXT, 8'h80, sym_a);
		settle();
		write_length(9'd3);

		// Three-byte pattern twice in a row, then rewrite its last byte mid-text
		for (int r = 0; r < 2; r++)
			for (int k = 0; k < 3; k++) push_item(MODE_TEXT, 8'h55, pattern_copy[k]);
		push_item(MODE_LOAD, 8'h02, ~pattern_copy[2]);
		for (int k = 0; k < 3; k++) push_item(MODE_TEXT, 8'hAA, pattern_copy[k]);

		// Random phases: sender idles lightly, then receiver lightly, then no idling
		for (int p = 0; p < PHASES; p++) begin
			send_idle = (p < 3) ? 11 : (p < 6) ? 46 : 0;
			recv_idle = (p < 3) ? 46 : (p < 6) ? 11 : 0;
			settle();
			write_length(phase_length(p));
			run_texts(180, span_of(phase_length(p)));
		end
		settle();

		$display("Ran %0d input transactions over %0d pattern lengths (0, 1 and 511 among them),",
			sb.items_seen, PHASES + 2);
		$display("checked %0d results with %0d full matches, %0d mismatches.",
			sb.results_seen, sb.hits_seen, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/epmc_pkg.sv
rtl/core/epmc_cell.sv
rtl/core/epmc_tally.sv
rtl/core/exact_pattern_match_counter.sv
verif/tb_exact_pattern_match_counter.sv
